/* rtl/sccd_pkg.sv */
// ----------------------------------------------------------------------------
// sccd_pkg: shared types and constants of the sector cache directory
// field widths of the stream payload, request codes and scan status flags
// ----------------------------------------------------------------------------
`default_nettype none

package sccd_pkg;

    localparam int OP_W     = 2;
    localparam int SECTOR_W = 32;
    localparam int NOW_W    = 32;
    localparam int SLOT_W   = 6;

    localparam int IN_DATA_W   = 64;  // sector, now
    localparam int OUT_DATA_W  = 40;  // slot, writeback_sector, zero pad
    localparam int OUT_USER_W  = 3;   // hit, fill_needed, writeback

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // status of one lookup scan
    typedef struct packed {
        logic found_hit;
        logic found_inv;
        logic found_min;
    } t_scan_flags;

endpackage

`default_nettype wire

/* rtl/sccd_scan_unit.sv */
// ----------------------------------------------------------------------------
// sccd_scan_unit: per-slot compare unit of the lookup scan
// takes one slot per cycle and keeps first hit, first free slot and oldest stamp
// ----------------------------------------------------------------------------
`default_nettype none

module sccd_scan_unit #(
    parameter int IDX_W      = 6,
    parameter int STAMP_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire                          i_vld,
    input  wire  [IDX_W-1:0]             i_idx,
    input  wire                          i_valid_bit,
    input  wire  [sccd_pkg::SECTOR_W-1:0] i_tag,
    input  wire  [STAMP_BITS-1:0]        i_stamp,
    input  wire  [sccd_pkg::SECTOR_W-1:0] i_sector,
    output sccd_pkg::t_scan_flags        o_flags,
    output logic [IDX_W-1:0]             o_hit_idx,
    output logic [IDX_W-1:0]             o_inv_idx,
    output logic [IDX_W-1:0]             o_min_idx,
    output logic [sccd_pkg::SECTOR_W-1:0] o_min_tag
);
    import sccd_pkg::*;

    t_scan_flags           r_flags;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [IDX_W-1:0]      r_inv_idx;
    logic [IDX_W-1:0]      r_min_idx;
    logic [SECTOR_W-1:0]   r_min_tag;
    logic [STAMP_BITS-1:0] r_min_stamp;

    logic take_hit;
    logic take_inv;
    logic take_min;

    // the single comparator pair shared by every slot of the scan
    assign take_hit = i_vld && i_valid_bit && !r_flags.found_hit && (i_tag == i_sector);
    assign take_inv = i_vld && !i_valid_bit && !r_flags.found_inv;
    assign take_min = i_vld && i_valid_bit &&
                      (!r_flags.found_min || (i_stamp < r_min_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
        end else begin
            if (take_hit) r_flags.found_hit <= 1'b1;
            if (take_inv) r_flags.found_inv <= 1'b1;
            if (take_min) r_flags.found_min <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_hit) r_hit_idx <= i_idx;
        if (take_inv) r_inv_idx <= i_idx;
        if (take_min) begin
            r_min_idx   <= i_idx;
            r_min_tag   <= i_tag;
            r_min_stamp <= i_stamp;
        end
    end

    assign o_flags   = r_flags;
    assign o_hit_idx = r_hit_idx;
    assign o_inv_idx = r_inv_idx;
    assign o_min_idx = r_min_idx;
    assign o_min_tag = r_min_tag;

endmodule

`default_nettype wire

/* rtl/sector_cache_directory_lru.sv */
// ----------------------------------------------------------------------------
// sector_cache_directory_lru: directory of a fully associative write-back
// sector cache with timestamp lru replacement
// ----------------------------------------------------------------------------
// usage
//   requests arrive on the s_axis channel: tuser carries the op (read, write,
//   flush), tdata the sector number and the current tick. results leave on the
//   m_axis channel, one transfer per result, tlast on the final result of a
//   request.
//   a read or write request scans all ENTRIES slots through one tag/stamp
//   compare unit, one slot per cycle, from the registered read port of the
//   tag and stamp memories. the look state issues the slot reads, the drain
//   state lets the last slot through the compare unit, and the decide state
//   loads the result; the next request is taken once the sequencer is idle.
//   a flush walks the dirty bits one slot per cycle, moves to the emit state
//   on each dirty slot for the tag read and the result, and stops at the last
//   dirty slot. a flush with nothing dirty gives one empty result. op code 3
//   is dropped without a result.
//   s_axis_tready is high only while the sequencer is idle; one request is
//   in work at a time. a result sits in the output register until taken, and
//   the sequencer holds before loading the next result while it is full.
//   reset clears valid and dirty bits, the sequencer and the output register;
//   no clearing pass is needed, the memory contents are used only for valid slots.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_directory_lru #(
    parameter int ENTRIES    = 64,
    parameter int STAMP_BITS = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // request channel
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [sccd_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // sector[31:0], now[63:32]
    input  wire  [sccd_pkg::OP_W-1:0]       s_axis_tuser,   // op[1:0]
    // result channel
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [sccd_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // slot[5:0], wb sector[37:6], 0
    output logic [sccd_pkg::OUT_USER_W-1:0] m_axis_tuser,   // hit[0], fill_needed[1], wb[2]
    output logic                            m_axis_tlast
);
    import sccd_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOK   = 7'b0000010,  // issue slot reads
        S_DRAIN  = 7'b0000100,  // last slot in the compare unit
        S_DECIDE = 7'b0001000,  // pick slot, update directory, give result
        S_FSCAN  = 7'b0010000,  // walk dirty bits
        S_FEMIT  = 7'b0100000,  // tag read done, give writeback result
        S_FEMPTY = 7'b1000000   // flush with nothing dirty
    } t_state;

    // sequencer and request registers
    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_cnt, n_cnt;
    t_op                   r_op;
    logic [SECTOR_W-1:0]   r_sector;
    logic [STAMP_BITS-1:0] r_now;
    logic                  r_pipe_vld;
    logic [IDX_W-1:0]      r_pipe_idx;

    // directory state held in flops
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [ENTRIES-1:0]    r_dirty, n_dirty;

    // tag and stamp memories with registered read
    logic [SECTOR_W-1:0]   tag_mem   [ENTRIES];
    logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
    logic [SECTOR_W-1:0]   r_tag_rd;
    logic [STAMP_BITS-1:0] r_stamp_rd;
    logic                  tag_we;
    logic                  stamp_we;
    logic [IDX_W-1:0]      wr_addr;

    // output register
    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_out_idx;
    logic                  r_out_hit;
    logic                  r_out_fill;
    logic                  r_out_wb;
    logic [SECTOR_W-1:0]   r_out_wsec;
    logic                  r_out_last;
    logic                  ld_out;
    logic [IDX_W-1:0]      n_out_idx;
    logic                  n_out_hit;
    logic                  n_out_fill;
    logic                  n_out_wb;
    logic [SECTOR_W-1:0]   n_out_wsec;
    logic                  n_out_last;

    logic                  in_xfer;
    logic                  issue;
    logic [ENTRIES-1:0]    dirty_rest;

    // scan results
    t_scan_flags           scan_flags;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      inv_idx;
    logic [IDX_W-1:0]      min_idx;
    logic [SECTOR_W-1:0]   min_tag;
    logic [IDX_W-1:0]      vic_idx;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign issue         = (r_state == S_LOOK);

    sccd_scan_unit #(
        .IDX_W      (IDX_W),
        .STAMP_BITS (STAMP_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_xfer),
        .i_vld       (r_pipe_vld),
        .i_idx       (r_pipe_idx),
        .i_valid_bit (r_valid[r_pipe_idx]),
        .i_tag       (r_tag_rd),
        .i_stamp     (r_stamp_rd),
        .i_sector    (r_sector),
        .o_flags     (scan_flags),
        .o_hit_idx   (hit_idx),
        .o_inv_idx   (inv_idx),
        .o_min_idx   (min_idx),
        .o_min_tag   (min_tag)
    );

    // victim: first free slot, else oldest stamp (lowest index on ties)
    assign vic_idx = scan_flags.found_inv ? inv_idx : min_idx;

    // dirty slots other than the one being flushed; all lie above it
    always_comb begin
        dirty_rest        = r_dirty;
        dirty_rest[r_cnt] = 1'b0;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_valid    = r_valid;
        n_dirty    = r_dirty;
        ld_out     = 1'b0;
        n_out_idx  = '0;
        n_out_hit  = 1'b0;
        n_out_fill = 1'b0;
        n_out_wb   = 1'b0;
        n_out_wsec = '0;
        n_out_last = 1'b1;
        tag_we     = 1'b0;
        stamp_we   = 1'b0;
        wr_addr    = r_cnt;

        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (in_xfer) begin
                    unique case (t_op'(s_axis_tuser))
                        OP_READ, OP_WRITE: n_state = S_LOOK;
                        OP_FLUSH:          n_state = (r_dirty == '0) ? S_FEMPTY : S_FSCAN;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOK: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_out_valid) begin
                    ld_out   = 1'b1;
                    stamp_we = 1'b1;
                    if (scan_flags.found_hit) begin
                        wr_addr   = hit_idx;
                        n_out_idx = hit_idx;
                        n_out_hit = 1'b1;
                    end else begin
                        wr_addr    = vic_idx;
                        n_out_idx  = vic_idx;
                        n_out_fill = 1'b1;
                        // a victim taken by stamp is always valid
                        n_out_wb   = !scan_flags.found_inv && r_dirty[min_idx];
                        n_out_wsec = n_out_wb ? min_tag : '0;
                        tag_we     = 1'b1;
                        n_valid[vic_idx] = 1'b1;
                        n_dirty[vic_idx] = 1'b0;
                    end
                    if (r_op == OP_WRITE) begin
                        n_dirty[wr_addr] = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FSCAN: begin
                if (r_dirty[r_cnt]) begin
                    n_state = S_FEMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FEMIT: begin
                if (!r_out_valid) begin
                    ld_out     = 1'b1;
                    n_out_idx  = r_cnt;
                    n_out_wb   = 1'b1;
                    n_out_wsec = r_tag_rd;
                    n_out_last = (dirty_rest == '0);
                    n_dirty    = dirty_rest;
                    n_cnt      = r_cnt + 1'b1;
                    n_state    = n_out_last ? S_IDLE : S_FSCAN;
                end
            end
            S_FEMPTY: begin
                if (!r_out_valid) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_pipe_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_valid    <= n_valid;
            r_dirty    <= n_dirty;
            r_pipe_vld <= issue;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_pipe_idx <= r_cnt;
        if (in_xfer) begin
            r_op     <= t_op'(s_axis_tuser);
            r_sector <= s_axis_tdata[SECTOR_W-1:0];
            r_now    <= STAMP_BITS'(s_axis_tdata[SECTOR_W +: NOW_W]);
        end
        if (ld_out) begin
            r_out_idx  <= n_out_idx;
            r_out_hit  <= n_out_hit;
            r_out_fill <= n_out_fill;
            r_out_wb   <= n_out_wb;
            r_out_wsec <= n_out_wsec;
            r_out_last <= n_out_last;
        end
    end

    // memories: one write port, read port follows the slot counter
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            tag_mem[wr_addr] <= r_sector;
        end
        r_tag_rd <= tag_mem[r_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            stamp_mem[wr_addr] <= r_now;
        end
        r_stamp_rd <= stamp_mem[r_cnt];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - SLOT_W - SECTOR_W)'(0), r_out_wsec,
                            SLOT_W'(r_out_idx)};
    assign m_axis_tuser  = {r_out_wb, r_out_fill, r_out_hit};
    assign m_axis_tlast  = r_out_last;

    // a flush result is only built for a slot that is dirty
    a_flush_dirty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FEMIT) |-> r_dirty[r_cnt])
        else $error("flush emit on a clean slot");

    // the final flush result leaves no dirty slot behind
    a_flush_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && (r_state == S_FEMIT) && n_out_last) |=> (r_dirty == '0))
        else $error("dirty slot left after flush");

    // a hit names a slot that is valid
    a_hit_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && (r_state == S_DECIDE) && scan_flags.found_hit) |-> r_valid[hit_idx])
        else $error("hit on an invalid slot");

    // a lookup result always leaves its slot valid
    a_slot_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && (r_state == S_DECIDE)) |=> r_valid[r_out_idx])
        else $error("lookup slot not valid after update");

endmodule

`default_nettype wire

/* dv/sccd_tb_pkg.sv */
// ----------------------------------------------------------------------------
// sccd_tb_pkg: result scoreboard of the sector cache directory bench
// mirrors the directory state and keeps the results owed by accepted requests
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sccd_tb_pkg;

    import sccd_pkg::*;

    localparam int DIR_SLOTS = 64;

    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                fill_needed;
        logic                writeback;
        logic [SECTOR_W-1:0] wb_sector;
        logic                last;
    } t_dir_result;

    class dir_scoreboard;

        bit                  valid_q [DIR_SLOTS];
        bit                  dirty_q [DIR_SLOTS];
        logic [SECTOR_W-1:0] tag_q   [DIR_SLOTS];
        logic [NOW_W-1:0]    stamp_q [DIR_SLOTS];
        t_dir_result         owed_results[$];
        int                  err_count;

        function new();
            for (int i = 0; i < DIR_SLOTS; i++) begin
                valid_q[i] = 1'b0;
                dirty_q[i] = 1'b0;
                tag_q[i]   = '0;
                stamp_q[i] = '0;
            end
            err_count = 0;
        endfunction

        // work out the results of one accepted request and update the mirror
        function void note_request(t_op op, logic [SECTOR_W-1:0] sector,
                                   logic [NOW_W-1:0] now);
            t_dir_result r;
            int          idx;
            int          n_wb;
            r    = '{default: '0};
            idx  = -1;
            n_wb = 0;
            case (op)
                OP_FLUSH: begin
                    for (int i = 0; i < DIR_SLOTS; i++) begin
                        if (dirty_q[i]) begin
                            r.slot      = SLOT_W'(i);
                            r.writeback = 1'b1;
                            r.wb_sector = tag_q[i];
                            owed_results.push_back(r);
                            dirty_q[i] = 1'b0;
                            n_wb++;
                        end
                    end
                    // nothing dirty: one empty result
                    if (n_wb == 0)
                        owed_results.push_back(r);
                    owed_results[owed_results.size()-1].last = 1'b1;
                end
                OP_READ, OP_WRITE: begin
                    for (int i = 0; i < DIR_SLOTS && idx < 0; i++)
                        if (valid_q[i] && tag_q[i] == sector)
                            idx = i;
                    if (idx >= 0) begin
                        r.hit = 1'b1;
                    end else begin
                        // first invalid slot, else oldest stamp, lowest index on ties
                        for (int i = 0; i < DIR_SLOTS && idx < 0; i++)
                            if (!valid_q[i])
                                idx = i;
                        if (idx < 0) begin
                            idx = 0;
                            for (int i = 1; i < DIR_SLOTS; i++)
                                if (stamp_q[i] < stamp_q[idx])
                                    idx = i;
                        end
                        r.fill_needed = 1'b1;
                        if (valid_q[idx] && dirty_q[idx]) begin
                            r.writeback = 1'b1;
                            r.wb_sector = tag_q[idx];
                        end
                        valid_q[idx] = 1'b1;
                        dirty_q[idx] = 1'b0;
                        tag_q[idx]   = sector;
                    end
                    stamp_q[idx] = now;
                    if (op == OP_WRITE)
                        dirty_q[idx] = 1'b1;
                    r.slot = SLOT_W'(idx);
                    r.last = 1'b1;
                    owed_results.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                err_count++;
            end
        endfunction

        // compare one result transfer with the oldest owed result
        function void check_result(logic [OUT_DATA_W-1:0] data,
                                   logic [OUT_USER_W-1:0] user, logic last);
            t_dir_result e;
            if (owed_results.size() == 0) begin
                $error("unexpected result: slot %0d, tuser 0x%0h", data[5:0], user);
                err_count++;
                return;
            end
            e = owed_results.pop_front();
            compare_field("slot", 32'(e.slot), 32'(data[5:0]));
            compare_field("hit", 32'(e.hit), 32'(user[0]));
            compare_field("fill_needed", 32'(e.fill_needed), 32'(user[1]));
            compare_field("writeback", 32'(e.writeback), 32'(user[2]));
            compare_field("writeback_sector", e.wb_sector, data[37:6]);
            compare_field("last", 32'(e.last), 32'(last));
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

    endclass

endpackage

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: bench of the sector cache directory
// directed and random read, write and flush requests against a mirrored
// directory; results are checked field by field under random source bursts
// and sink stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import sccd_pkg::*;
    import sccd_tb_pkg::*;

    localparam int RANDOM_REQS = 350;
    localparam int POOL_SIZE   = 96;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 2 * DIR_SLOTS + 16;  // beyond a full scan

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // request channel
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;      // sector[31:0], now[63:32]
    logic [OP_W-1:0]       s_tuser  = '0;      // op[1:0]

    // result channel
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;            // slot[5:0], wb sector[37:6], pad
    logic [OUT_USER_W-1:0] m_tuser;            // hit[0], fill_needed[1], wb[2]
    logic                  m_tlast;

    dir_scoreboard sb = new();

    int unsigned   cycle_count = 0;
    logic [31:0]   sector_pool [POOL_SIZE];
    logic [31:0]   tick = 32'd100;

    sector_cache_directory_lru dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // result sink: a transfer happens when valid and ready meet at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // sink stall pattern: free running, steady random, or a periodic pattern
    initial begin : sink_pattern
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(32, 256);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 2) != 0);
                    default: m_tready <= (k % 4 == 3);
                endcase
            end
        end
    end

    // one request transfer; called and returns at a falling edge
    task automatic send_request(t_op op, logic [31:0] sector, logic [31:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {now, sector};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(op, sector, now);
        @(negedge i_clk);
    endtask

    // source gap between bursts; valid drops only when a gap is taken
    task automatic source_gap(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // access tick: mostly rising, sometimes repeated so stamps tie, now and then wild
    function automatic logic [31:0] next_now();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return $urandom;
        if (r <= 3)
            return tick;
        tick = tick + $urandom_range(1, 5);
        return tick;
    endfunction

    initial begin : stimulus
        int   n_done;
        int   burst_left;
        int   r;
        t_op  op;
        logic [31:0] sector;

        sector_pool[0] = 32'h0000_0000;
        sector_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            sector_pool[i] = $urandom;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        send_request(OP_FLUSH, 32'h1234_5678, 32'd7);          // flush, nothing dirty
        send_request(OP_NONE, 32'hDEAD_BEEF, 32'hFFFF_FFFF);   // dropped code
        send_request(OP_READ, 32'h0000_0000, 32'h0000_0000);   // miss into slot 0
        send_request(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // miss into slot 1, dirty
        source_gap(3);
        send_request(OP_READ, 32'h0000_0000, 32'd5);           // read hit
        send_request(OP_WRITE, 32'h0000_0000, 32'd6);          // write hit, dirty
        send_request(OP_WRITE, 32'h8000_0001, 32'd6);          // same stamp as slot 0
        send_request(OP_READ, 32'h7FFF_FFFE, 32'd6);
        send_request(OP_FLUSH, 32'hFFFF_FFFF, 32'd0);          // three writebacks
        send_request(OP_FLUSH, 32'h0, 32'd0);                  // clean again: empty result
        send_request(OP_WRITE, 32'hFFFF_FFFF, 32'd9);          // write hit on clean slot
        send_request(OP_NONE, 32'h0, 32'h0);
        send_request(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_WRITE, 32'h5555_AAAA, 32'hAAAA_5555);
        send_request(OP_FLUSH, 32'h0, 32'd0);

        // random part: a working set a bit larger than the directory, so hits,
        // fills of invalid slots and lru evictions of dirty slots all happen
        n_done     = 0;
        burst_left = $urandom_range(1, 12);
        while (n_done < RANDOM_REQS) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op = OP_READ;
            else if (r < 89)
                op = OP_WRITE;
            else if (r < 96)
                op = OP_FLUSH;
            else
                op = OP_NONE;
            if ($urandom_range(0, 15) == 0)
                sector = $urandom;
            else
                sector = sector_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(op, sector, next_now());
            if (op != OP_NONE)
                n_done++;
            burst_left--;
            if (burst_left == 0) begin
                // a quarter of the bursts run straight into the next one
                if ($urandom_range(0, 3) != 0)
                    source_gap($urandom_range(1, 10));
                burst_left = $urandom_range(1, 12);
            end
        end
        s_tvalid <= 1'b0;

        // wait for every owed result, then let any late transfer show up
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
